// ----- rtl/core/prtl_pkg.sv -----
// Package for the priority task ready list: sizes, codes, slot entry layout,
// sequencer states and the result struct. No dependencies.
package prtl_pkg;

  localparam int SLOT_COUNT    = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int IDX_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LINK_W        = $clog2(SLOT_COUNT + 1);
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOT_COUNT);

  localparam logic [1:0] MODE_ACT  = 2'd0;
  localparam logic [1:0] MODE_TERM = 2'd1;
  localparam logic [1:0] MODE_DISP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] pri;
    logic [LINK_W-1:0]        nxt;
    logic [LINK_W-1:0]        prv;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_S, S_U_P, S_U_PW, S_U_N, S_U_NW,
    S_L_START, S_L_CHK, S_L_CMP, S_L_WS, S_L_WB, S_L_WA,
    S_PICK, S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0] op_status;
    logic [3:0] task_slot;
    logic [3:0] running_slot;
    logic       running_valid;
    logic [4:0] ready_count;
  } res_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] x);
    return x < NIL_LINK;
  endfunction

endpackage

// ----- rtl/core/priority_task_ready_list.sv -----
// Top level of the priority task ready list: entry RAM, sequencer and the
// result output register. Uses prtl_pkg, prtl_seq, prtl_ram.
//
// Usage:
//  - Input channel (in_valid/in_ready): one word per scheduler call, with
//    in_mode (activate, terminate running task, dispatch) and
//    in_priority_req (used by activate only).
//  - Result channel (out_valid/out_ready): one word per call with status,
//    the slot given on activate, the running slot and the active count.
//  - Calls are handled one at a time. An activate walks the list, one RAM
//    read per list entry, past each task of equal or higher priority; a
//    dispatch first unlinks the running task and then walks the list the
//    same way. The worst case is set by this priority walk.
//  - A call that changes no list links (full table, idle terminate, idle
//    dispatch, mode three) posts its result straight from idle.
//  - Reset (rst_n low, synchronous) frees all slots, empties the list and
//    idles the block; entry RAM contents are not cleared and need not be.
//  - The result is held in an output register; if the receiver stalls, the
//    next call may be taken and worked, and it waits until the register
//    frees before posting its word.
module priority_task_ready_list (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_priority_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_op_status,
  output logic [3:0] out_task_slot,
  output logic [3:0] out_running_slot,
  output logic       out_running_valid,
  output logic [4:0] out_ready_count
);
  import prtl_pkg::*;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  ent_t             wdata, rdata;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r;

  // slot entries: priority plus list links
  prtl_ram #(.WIDTH(ENT_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  prtl_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .we              (we),
    .waddr           (waddr),
    .wdata           (wdata),
    .raddr           (raddr),
    .rdata           (rdata),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // output register: loads whenever empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_op_status     = out_r.op_status;
  assign out_task_slot     = out_r.task_slot;
  assign out_running_slot  = out_r.running_slot;
  assign out_running_valid = out_r.running_valid;
  assign out_ready_count   = out_r.ready_count;
endmodule

// ----- rtl/core/prtl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module prtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/prtl_seq.sv -----
// Scheduler sequencer: walks and relinks the slot list in the entry RAM,
// keeps head, running task, task count and slot busy bits. Uses prtl_pkg.
module prtl_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [7:0]                      in_priority_req,
  output logic                            we,
  output logic [prtl_pkg::IDX_W-1:0]      waddr,
  output prtl_pkg::ent_t                  wdata,
  output logic [prtl_pkg::IDX_W-1:0]      raddr,
  input  prtl_pkg::ent_t                  rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output prtl_pkg::res_t                  res
);
  import prtl_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  logic [IDX_W-1:0]         s_r, s_nxt;
  logic [LINK_W-1:0]        p_r, p_nxt, n_r, n_nxt;
  logic [LINK_W-1:0]        before_r, before_nxt, after_r, after_nxt;
  logic [LINK_W-1:0]        head_r, head_nxt, cur_r, cur_nxt, pick;
  logic [LINK_W-1:0]        count_r, count_nxt, guard_r, guard_nxt;
  ent_t                     bword_r, bword_nxt, aword_r, aword_nxt;
  logic [SLOT_COUNT-1:0]    busy_r, busy_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [IDX_W-1:0]         given_r, given_nxt;
  logic [15:0]              pri_ext;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [LINK_W-1:0]        s_link;

  assign pri_ext = {8'b0, in_priority_req};
  assign s_link  = LINK_W'(s_r);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NIL_LINK;
      cur_r   <= NIL_LINK;
      count_r <= '0;
      busy_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cur_r   <= cur_nxt;
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    pri_r    <= pri_nxt;
    s_r      <= s_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    before_r <= before_nxt;
    after_r  <= after_nxt;
    guard_r  <= guard_nxt;
    bword_r  <= bword_nxt;
    aword_r  <= aword_nxt;
    status_r <= status_nxt;
    given_r  <= given_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pri_nxt    = pri_r;
    s_nxt      = s_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    before_nxt = before_r;
    after_nxt  = after_r;
    guard_nxt  = guard_r;
    bword_nxt  = bword_r;
    aword_nxt  = aword_r;
    head_nxt   = head_r;
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    busy_nxt   = busy_r;
    status_nxt = status_r;
    given_nxt  = given_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    we         = 1'b0;
    waddr      = s_r;
    wdata      = '{pri: pri_r, nxt: after_r, prv: before_r};
    raddr      = s_r;
    pick       = is_slot(n_r) ? n_r : head_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt   = in_mode;
          status_nxt = ST_DONE;
          given_nxt  = '0;
          n_nxt      = NIL_LINK;
          state_nxt  = S_DONE;
          case (in_mode)
            MODE_ACT: begin
              if (free_found) begin
                s_nxt              = free_idx;
                pri_nxt            = pri_ext[PRIORITY_BITS-1:0];
                busy_nxt[free_idx] = 1'b1;
                count_nxt          = count_r + 1'b1;
                given_nxt          = free_idx;
                state_nxt          = S_L_START;
              end else begin
                status_nxt = ST_FULL;
              end
            end
            MODE_TERM: begin
              if (is_slot(cur_r)) begin
                s_nxt     = IDX_W'(cur_r);
                raddr     = IDX_W'(cur_r);
                state_nxt = S_RD_S;
              end else begin
                status_nxt = ST_NONE;
              end
            end
            MODE_DISP: begin
              if (is_slot(cur_r)) begin
                s_nxt     = IDX_W'(cur_r);
                raddr     = IDX_W'(cur_r);
                state_nxt = S_RD_S;
              end else if (is_slot(head_r)) begin
                cur_nxt = head_r;
              end else begin
                status_nxt = ST_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_S: begin
        p_nxt   = rdata.prv;
        n_nxt   = rdata.nxt;
        pri_nxt = rdata.pri;
        if (head_r == s_link) head_nxt = rdata.nxt;
        if (mode_r == MODE_TERM) begin
          busy_nxt[s_r] = 1'b0;
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
        state_nxt = S_U_P;
      end
      S_U_P: begin
        raddr     = IDX_W'(p_r);
        state_nxt = is_slot(p_r) ? S_U_PW : S_U_N;
      end
      S_U_PW: begin
        we        = 1'b1;
        waddr     = IDX_W'(p_r);
        wdata     = rdata;
        wdata.nxt = n_r;
        state_nxt = S_U_N;
      end
      S_U_N: begin
        raddr = IDX_W'(n_r);
        if (is_slot(n_r)) state_nxt = S_U_NW;
        else state_nxt = (mode_r == MODE_DISP) ? S_L_START : S_PICK;
      end
      S_U_NW: begin
        we        = 1'b1;
        waddr     = IDX_W'(n_r);
        wdata     = rdata;
        wdata.prv = p_r;
        state_nxt = (mode_r == MODE_DISP) ? S_L_START : S_PICK;
      end
      S_L_START: begin
        before_nxt = NIL_LINK;
        after_nxt  = head_r;
        guard_nxt  = '0;
        state_nxt  = S_L_CHK;
      end
      S_L_CHK: begin
        raddr = IDX_W'(after_r);
        if (is_slot(after_r) && guard_r < NIL_LINK) state_nxt = S_L_CMP;
        else state_nxt = S_L_WS;
      end
      S_L_CMP: begin
        if (rdata.pri >= pri_r) begin
          before_nxt = after_r;
          bword_nxt  = rdata;
          after_nxt  = rdata.nxt;
          guard_nxt  = guard_r + 1'b1;
          state_nxt  = S_L_CHK;
        end else begin
          aword_nxt = rdata;
          state_nxt = S_L_WS;
        end
      end
      S_L_WS: begin
        we = 1'b1;
        if (is_slot(before_r)) begin
          state_nxt = S_L_WB;
        end else begin
          head_nxt  = s_link;
          state_nxt = S_L_WA;
        end
      end
      S_L_WB: begin
        we        = 1'b1;
        waddr     = IDX_W'(before_r);
        wdata     = bword_r;
        wdata.nxt = s_link;
        state_nxt = S_L_WA;
      end
      S_L_WA: begin
        we        = is_slot(after_r);
        waddr     = IDX_W'(after_r);
        wdata     = aword_r;
        wdata.prv = s_link;
        state_nxt = (mode_r == MODE_ACT) ? S_DONE : S_PICK;
      end
      S_PICK: begin
        if (is_slot(pick)) begin
          cur_nxt = pick;
        end else begin
          cur_nxt    = NIL_LINK;
          status_nxt = ST_NONE;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.op_status     = status_r;
  assign res.task_slot     = 4'(given_r);
  assign res.running_slot  = is_slot(cur_r) ? 4'(cur_r) : 4'd0;
  assign res.running_valid = is_slot(cur_r);
  assign res.ready_count   = 5'(count_r);
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for priority_task_ready_list: directed table, fill/empty, then random
// calls, each result checked against an in-bench scheduler model. Uses prtl_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import prtl_pkg::*;

  localparam int MODE_NOP = 3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] C_FREE = 2'd0, C_READY = 2'd1, C_RUN = 2'd2;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = '0;
  logic [7:0] in_priority_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_op_status;
  logic [3:0] out_task_slot;
  logic [3:0] out_running_slot;
  logic       out_running_valid;
  logic [4:0] out_ready_count;

  always #5 clk = ~clk;

  priority_task_ready_list dut (.*);

  // scheduler model state; a null link is the value SLOT_COUNT
  logic [7:0] pri_tab [SLOT_COUNT];
  logic [1:0] cond_tab [SLOT_COUNT];
  int         nxt_tab [SLOT_COUNT];
  int         prv_tab [SLOT_COUNT];
  int         head_slot, run_slot_q, active_cnt;

  res_t expected_words [$];
  int   mismatches = 0;
  int   words_seen = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;     // last part of the run: no idling
  int   n_act = 0, n_term = 0, n_disp = 0, n_full = 0;

  function automatic bit valid_slot(int s);
    return s >= 0 && s < SLOT_COUNT;
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cond_tab[i] = C_FREE;
      nxt_tab[i] = SLOT_COUNT;
      prv_tab[i] = SLOT_COUNT;
      pri_tab[i] = '0;
    end
    head_slot = SLOT_COUNT;
    run_slot_q = SLOT_COUNT;
    active_cnt = 0;
  endfunction

  function automatic void list_remove(int s);
    int p, n;
    p = prv_tab[s];
    n = nxt_tab[s];
    if (head_slot == s) head_slot = n;
    if (valid_slot(p)) nxt_tab[p] = n;
    if (valid_slot(n)) prv_tab[n] = p;
    nxt_tab[s] = SLOT_COUNT;
    prv_tab[s] = SLOT_COUNT;
  endfunction

  // insert behind every task of equal or higher priority
  function automatic void list_insert(int s);
    int b, a, g;
    b = SLOT_COUNT;
    a = head_slot;
    g = 0;
    while (valid_slot(a) && pri_tab[a] >= pri_tab[s] && g < SLOT_COUNT) begin
      b = a;
      a = nxt_tab[a];
      g++;
    end
    prv_tab[s] = b;
    nxt_tab[s] = a;
    if (valid_slot(b)) nxt_tab[b] = s;
    else head_slot = s;
    if (valid_slot(a)) prv_tab[a] = s;
  endfunction

  function automatic void start_task(int s);
    if (valid_slot(s)) begin
      cond_tab[s] = C_RUN;
      run_slot_q = s;
    end else begin
      run_slot_q = SLOT_COUNT;
    end
  endfunction

  // one scheduler call: update state, return the word it answers with
  function automatic res_t sched_call(logic [1:0] mode, logic [7:0] pri);
    res_t r;
    int s, succ, pick;
    r = '0;
    r.op_status = ST_DONE;
    case (mode)
      MODE_ACT: begin
        s = SLOT_COUNT;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (cond_tab[i] == C_FREE) s = i;
        if (!valid_slot(s)) begin
          r.op_status = ST_FULL;
        end else begin
          pri_tab[s] = pri;
          cond_tab[s] = C_READY;
          active_cnt++;
          list_insert(s);
          r.task_slot = s[3:0];
        end
      end
      MODE_TERM: begin
        s = run_slot_q;
        if (!valid_slot(s)) begin
          r.op_status = ST_NONE;
        end else begin
          succ = nxt_tab[s];
          cond_tab[s] = C_FREE;
          list_remove(s);
          if (active_cnt > 0) active_cnt--;
          run_slot_q = SLOT_COUNT;
          pick = valid_slot(succ) ? succ : head_slot;
          if (valid_slot(pick)) start_task(pick);
          else r.op_status = ST_NONE;
        end
      end
      MODE_DISP: begin
        s = run_slot_q;
        if (!valid_slot(s)) begin
          if (valid_slot(head_slot)) start_task(head_slot);
          else r.op_status = ST_NONE;
        end else begin
          succ = nxt_tab[s];
          cond_tab[s] = C_READY;
          list_remove(s);
          list_insert(s);
          pick = valid_slot(succ) ? succ : head_slot;
          if (valid_slot(pick)) start_task(pick);
          else r.op_status = ST_NONE;
        end
      end
      default: ;
    endcase
    r.running_valid = valid_slot(run_slot_q);
    r.running_slot = r.running_valid ? run_slot_q[3:0] : 4'd0;
    r.ready_count = active_cnt[4:0];
    return r;
  endfunction

  // directed table; chk marks rows whose word is typed in
  typedef struct {
    logic [1:0] mode;
    logic [7:0] pri;
    bit         chk;
    res_t       want;
  } call_row_t;

  call_row_t calls [] = '{
    '{MODE_TERM, 8'h00, 1, '{ST_NONE, 4'd0, 4'd0, 1'b0, 5'd0}}, // idle terminate
    '{MODE_DISP, 8'h00, 1, '{ST_NONE, 4'd0, 4'd0, 1'b0, 5'd0}}, // empty dispatch
    '{2'(MODE_NOP), 8'hFF, 1, '{ST_DONE, 4'd0, 4'd0, 1'b0, 5'd0}},
    '{MODE_ACT,  8'h00, 1, '{ST_DONE, 4'd0, 4'd0, 1'b0, 5'd1}},
    '{MODE_DISP, 8'h00, 1, '{ST_DONE, 4'd0, 4'd0, 1'b1, 5'd1}}, // lone task
    '{MODE_DISP, 8'h00, 1, '{ST_DONE, 4'd0, 4'd0, 1'b1, 5'd1}}, // wraps to itself
    '{MODE_TERM, 8'h00, 1, '{ST_NONE, 4'd0, 4'd0, 1'b0, 5'd0}}, // last task
    '{MODE_ACT,  8'hFF, 0, '0},
    '{MODE_ACT,  8'h55, 0, '0},
    '{MODE_ACT,  8'hAA, 0, '0},
    '{MODE_ACT,  8'hFF, 0, '0},
    '{MODE_ACT,  8'h00, 0, '0},
    '{MODE_DISP, 8'h00, 0, '{default: '0}},
    '{MODE_DISP, 8'h00, 0, '0},
    '{MODE_DISP, 8'h00, 0, '0},
    '{MODE_TERM, 8'h00, 0, '0},
    '{MODE_DISP, 8'h00, 0, '0},
    '{MODE_TERM, 8'h00, 0, '0},
    '{2'(MODE_NOP), 8'h00, 0, '0}
  };

  // hand one word over; sender idles in bursts unless quiet.
  // valid stays up after the handshake until the next word, an idle burst or a drain
  task automatic send_word(logic [1:0] mode, logic [7:0] pri);
    res_t w;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_priority_req <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    w = sched_call(mode, pri);
    expected_words.push_back(w);
    case (mode)
      MODE_ACT: begin
        n_act++;
        if (w.op_status == ST_FULL) n_full++;
      end
      MODE_TERM: n_term++;
      MODE_DISP: n_disp++;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, none once quiet
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker, sampled at the edge
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_op_status, out_task_slot, out_running_slot,
              out_running_valid, out_ready_count};
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d mismatch: expected %p got %p", words_seen, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r, m;
    res_t pred;
    sched_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: typed-in words are compared to the model too
    foreach (calls[i]) begin
      send_word(calls[i].mode, calls[i].pri);
      if (calls[i].chk) begin
        pred = expected_words[$];
        if (pred !== calls[i].want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: model %p table %p", i, pred, calls[i].want);
        end
      end
    end

    // fill the table past full, then empty it
    for (int i = 0; i < SLOT_COUNT + 2; i++) send_word(MODE_ACT, 8'($urandom));
    drain();  // sender holds off until all answers are in
    for (int i = 0; i < SLOT_COUNT + 2; i++) send_word(MODE_TERM, 8'($urandom));
    send_word(MODE_DISP, 8'h00);

    // random: mostly activate/dispatch/terminate mixes, some noise priorities
    for (int i = 0; i < 1600; i++) begin
      if (i == 1450) quiet = 1'b1;
      if (i % 400 == 200) drain();
      r = $urandom_range(0, 99);
      if (r < 40) m = MODE_ACT;
      else if (r < 65) m = MODE_TERM;
      else if (r < 95) m = MODE_DISP;
      else m = MODE_NOP;
      send_word(2'(m), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom));
    end

    drain();
    repeat (60) @(posedge clk);
    $display("%0d words checked: %0d activate (%0d full), %0d terminate, %0d dispatch",
             words_seen, n_act, n_full, n_term, n_disp);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
